@@ hdl/ond_pkg.sv @@
// Shared constants, pipeline record types and arithmetic helpers of the Oren-Nayar unit.
package ond_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE >> 1;

    // Material constants rounded to the fixed-point grid.
    localparam int C33 = (ONE * 33 + 50) / 100;
    localparam int C09 = (ONE * 9 + 50) / 100;
    localparam int C45 = (ONE * 45 + 50) / 100;
    localparam int TH  = (ONE * 9999 + 5000) / 10000;

    localparam logic [14:0] OREN_A_RESET = 15'(ONE);
    localparam logic [12:0] OREN_B_RESET = 13'd0;

    typedef enum logic [7:0] {
        REG_OREN_A = 8'd0,
        REG_OREN_B = 8'd1
    } t_cfg_reg;

    // Pipeline schedule: the register stage at which each step starts, and the digit counts of the unrolled loops.
    localparam int ST_MUL      = 1;
    localparam int ST_COS      = 2;
    localparam int ST_PROJ     = 3;
    localparam int ST_TAN      = 4;
    localparam int ST_PROD     = 5;
    localparam int ST_SUM      = 6;
    localparam int ST_SQRT     = 7;
    localparam int SQRT_STEPS  = 18;
    localparam int SIG_STEPS   = 14;
    localparam int ST_DEN      = ST_SQRT + SQRT_STEPS;
    localparam int ST_AZINIT   = ST_DEN + 1;
    localparam int ST_AZDIV    = ST_AZINIT + 1;
    localparam int AZ_STEPS    = 15;
    localparam int ST_AZ       = ST_AZDIV + AZ_STEPS;
    localparam int ST_T1       = ST_AZ + 1;
    localparam int ST_TERM     = ST_T1 + 1;
    localparam int ST_QMUL     = ST_TERM + 1;
    localparam int ST_QINIT    = ST_QMUL + 1;
    localparam int ST_QDIV     = ST_QINIT + 1;
    localparam int Q_STEPS     = 16;
    localparam int ST_RES      = ST_QDIV + Q_STEPS;
    localparam int N_STAGES    = ST_RES + 1;

    typedef struct packed {
        logic [35:0] x;
        logic [19:0] rem;
        logic [17:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [30:0] rem;
        logic [17:0] den;
        logic [13:0] quo;
    } t_div_sig;

    typedef struct packed {
        logic        take;
        logic [50:0] rem;
    } t_dstep;

    typedef struct {
        logic signed [15:0] wi [3];
        logic signed [15:0] wo [3];
        logic signed [15:0] nv [3];
        logic               use_sig;
        logic        [14:0] sig;
        logic signed [31:0] pi [3];
        logic signed [31:0] po [3];
        logic        [29:0] sgsq;
        logic signed [15:0] ci;
        logic signed [15:0] co;
        logic signed [15:0] cb;
        logic        [15:0] s2;
        logic signed [31:0] nci [3];
        logic signed [31:0] nco [3];
        logic               az_en;
        logic signed [17:0] v1 [3];
        logic signed [17:0] v2 [3];
        logic signed [34:0] pd [3];
        logic        [33:0] p1 [3];
        logic        [33:0] p2 [3];
        logic signed [36:0] dot;
        t_sqrt              sq [4];
        t_div_sig           dva;
        t_div_sig           dvb;
        logic        [35:0] az_den;
        logic               az_ok;
        logic        [14:0] a_sel;
        logic        [12:0] b_sel;
        logic        [48:0] az_rem;
        logic        [14:0] az_quo;
        logic               az_ovf;
        logic        [14:0] az;
        logic        [12:0] t1;
        logic        [12:0] term;
        logic        [26:0] q_rem;
        logic        [14:0] q_den;
        logic        [15:0] q_quo;
        logic               q_ovf;
        logic        [14:0] res;
    } t_pl;

    // Signed round to nearest, ties away from zero, after dropping the fraction bits.
    function automatic logic signed [21:0] rnd_s(input logic signed [35:0] x);
        logic [35:0] mag;
        logic [21:0] m;
        mag = x[35] ? 36'(-x) : 36'(x);
        m   = 22'((mag + 36'(HALF)) >> FRAC_BITS);
        return x[35] ? -$signed(m) : $signed(m);
    endfunction

    // One digit of a restoring square root, two radicand bits per step.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       r;
        logic [21:0] acc;
        logic [21:0] trial;
        acc   = {s.rem, s.x[35:34]};
        trial = {2'b00, s.root, 2'b01};
        r.x   = {s.x[33:0], 2'b00};
        if (acc >= trial) begin
            r.rem  = 20'(acc - trial);
            r.root = {s.root[16:0], 1'b1};
        end else begin
            r.rem  = acc[19:0];
            r.root = {s.root[16:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring division against the divisor shifted by sh.
    function automatic t_dstep div_step(input logic [50:0] rem, input logic [35:0] den,
                                        input int sh);
        t_dstep      r;
        logic [50:0] d;
        d      = 51'(den) << sh;
        r.take = (rem >= d);
        r.rem  = r.take ? rem - d : rem;
        return r;
    endfunction

endpackage

@@ hdl/oren_nayar_diffuse_factor.sv @@
// Pipelined Oren-Nayar diffuse scale unit with its A and B configuration registers.
// Throughput: one transaction per cycle while the output is not stalled; every square root and division is unrolled
// into one register stage per digit, so the 64 stages all advance together.
// Reset (synchronous, active low) empties the pipeline and sets oren_a to 1.0, oren_b to 0.
// A stalled output freezes the pipeline; an empty first stage still takes one more input.
module oren_nayar_diffuse_factor
    import ond_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [7:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_in_dir_x,
    input  logic signed [15:0] i_in_dir_y,
    input  logic signed [15:0] i_in_dir_z,
    input  logic signed [15:0] i_out_dir_x,
    input  logic signed [15:0] i_out_dir_y,
    input  logic signed [15:0] i_out_dir_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic               i_use_item_sigma,
    input  logic        [14:0] i_item_sigma,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [14:0] o_diffuse_scale
);

    // Configuration registers. The user must issue writes only while the pipeline is empty,
    // so the late stages can read them directly; the block itself does not enforce this.
    logic [14:0] r_oren_a;
    logic [12:0] r_oren_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oren_a <= OREN_A_RESET;
            r_oren_b <= OREN_B_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OREN_A: r_oren_a <= i_cfg_data[14:0];
                REG_OREN_B: r_oren_b <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Work done in each pipeline stage. The stage number is a constant at every call,
    // so each instance reduces to the logic of its own stage.
    function automatic t_pl stage_fn(input int k, input t_pl p,
                                     input logic [14:0] reg_a, input logic [12:0] reg_b);
        t_pl                s;
        logic signed [35:0] sum;
        logic signed [21:0] c;
        logic signed [15:0] ca;
        logic        [14:0] m;
        logic        [29:0] msq;
        t_dstep             ds;
        int                 sh;
        int                 j;
        s   = p;
        sum = '0;
        c   = '0;
        ca  = '0;
        m   = '0;
        msq = '0;
        sh  = 0;
        if (k == ST_MUL) begin
            for (j = 0; j < 3; j++) begin
                s.pi[j] = 32'(p.nv[j]) * 32'(p.wi[j]);
                s.po[j] = 32'(p.nv[j]) * 32'(p.wo[j]);
            end
            s.sgsq = 30'(p.sig) * 30'(p.sig);
        end else if (k == ST_COS) begin
            // Clamped cosines of both directions against the normal.
            sum = 36'(p.pi[0]) + 36'(p.pi[1]) + 36'(p.pi[2]);
            c   = rnd_s(sum);
            if (c > ONE) c = 22'(ONE);
            if (c < -ONE) c = -22'(ONE);
            s.ci = 16'(c);
            sum = 36'(p.po[0]) + 36'(p.po[1]) + 36'(p.po[2]);
            c   = rnd_s(sum);
            if (c > ONE) c = 22'(ONE);
            if (c < -ONE) c = -22'(ONE);
            s.co = 16'(c);
            s.s2 = 16'((31'(p.sgsq) + 31'(HALF)) >> FRAC_BITS);
        end else if (k == ST_PROJ) begin
            for (j = 0; j < 3; j++) begin
                s.nci[j] = 32'(p.nv[j]) * 32'(p.ci);
                s.nco[j] = 32'(p.nv[j]) * 32'(p.co);
            end
            s.az_en = (p.ci < TH) && (p.co < TH);
            if (p.co >= p.ci) begin
                ca   = p.ci;
                s.cb = p.co;
            end else begin
                ca   = p.co;
                s.cb = p.ci;
            end
            // Sine radicands for the larger angle (alpha) and the smaller one (beta).
            m   = ca[15] ? 15'(-ca) : 15'(ca);
            msq = 30'(m) * 30'(m);
            s.sq[2].x    = 36'(30'(ONE * ONE) - msq);
            s.sq[2].rem  = '0;
            s.sq[2].root = '0;
            m   = s.cb[15] ? 15'(-s.cb) : 15'(s.cb);
            msq = 30'(m) * 30'(m);
            s.sq[3].x    = 36'(30'(ONE * ONE) - msq);
            s.sq[3].rem  = '0;
            s.sq[3].root = '0;
            // Roughness terms: A needs s2*ONE / (2*(s2+C33)), B needs C45*s2 / (s2+C09).
            s.dva.rem = (31'(p.s2) << FRAC_BITS) + 31'(p.s2) + 31'(C33);
            s.dva.den = (18'(p.s2) + 18'(C33)) << 1;
            s.dva.quo = '0;
            s.dvb.rem = 31'(29'(p.s2) * 29'(C45) + 29'((17'(p.s2) + 17'(C09)) >> 1));
            s.dvb.den = 18'(17'(p.s2) + 17'(C09));
            s.dvb.quo = '0;
        end else if (k == ST_TAN) begin
            for (j = 0; j < 3; j++) begin
                s.v1[j] = 18'(p.wi[j]) - 18'(rnd_s(36'(p.nci[j])));
                s.v2[j] = 18'(p.wo[j]) - 18'(rnd_s(36'(p.nco[j])));
            end
        end else if (k == ST_PROD) begin
            for (j = 0; j < 3; j++) begin
                s.pd[j] = 35'(36'(p.v1[j]) * 36'(p.v2[j]));
                s.p1[j] = 34'($unsigned(36'(p.v1[j]) * 36'(p.v1[j])));
                s.p2[j] = 34'($unsigned(36'(p.v2[j]) * 36'(p.v2[j])));
            end
        end else if (k == ST_SUM) begin
            s.dot = 37'(p.pd[0]) + 37'(p.pd[1]) + 37'(p.pd[2]);
            s.sq[0].x    = 36'(35'(p.p1[0]) + 35'(p.p1[1]) + 35'(p.p1[2]));
            s.sq[0].rem  = '0;
            s.sq[0].root = '0;
            s.sq[1].x    = 36'(35'(p.p2[0]) + 35'(p.p2[1]) + 35'(p.p2[2]));
            s.sq[1].rem  = '0;
            s.sq[1].root = '0;
        end else if (k >= ST_SQRT && k < ST_SQRT + SQRT_STEPS) begin
            // Four square roots run side by side; the roughness divisions share the span.
            for (j = 0; j < 4; j++) begin
                s.sq[j] = sqrt_step(p.sq[j]);
            end
            if (k - ST_SQRT < SIG_STEPS) begin
                sh = SIG_STEPS - 1 - (k - ST_SQRT);
                ds = div_step(51'(p.dva.rem), 36'(p.dva.den), sh);
                s.dva.rem = ds.rem[30:0];
                s.dva.quo = {p.dva.quo[12:0], ds.take};
                ds = div_step(51'(p.dvb.rem), 36'(p.dvb.den), sh);
                s.dvb.rem = ds.rem[30:0];
                s.dvb.quo = {p.dvb.quo[12:0], ds.take};
            end
        end else if (k == ST_DEN) begin
            s.az_den = 36'(p.sq[0].root) * 36'(p.sq[1].root);
            s.az_ok  = p.az_en && (p.dot > 0) && (p.sq[0].root != '0) && (p.sq[1].root != '0);
            if (p.use_sig) begin
                s.a_sel = 15'(ONE) - 15'(p.dva.quo);
                s.b_sel = p.dvb.quo[12:0];
            end else begin
                s.a_sel = reg_a;
                s.b_sel = reg_b;
            end
        end else if (k == ST_AZINIT) begin
            s.az_rem = 49'(p.dot[34:0]) << FRAC_BITS;
            s.az_quo = '0;
            s.az_ovf = (51'(s.az_rem) >= (51'(p.az_den) << AZ_STEPS));
        end else if (k >= ST_AZDIV && k < ST_AZDIV + AZ_STEPS) begin
            sh = AZ_STEPS - 1 - (k - ST_AZDIV);
            ds = div_step(51'(p.az_rem), p.az_den, sh);
            s.az_rem = ds.rem[48:0];
            s.az_quo = {p.az_quo[13:0], ds.take};
        end else if (k == ST_AZ) begin
            if (!p.az_ok) begin
                s.az = '0;
            end else if (p.az_ovf || (p.az_quo > 15'(ONE))) begin
                s.az = 15'(ONE);
            end else begin
                s.az = p.az_quo;
            end
        end else if (k == ST_T1) begin
            s.t1 = 13'((28'(p.b_sel) * 28'(p.az) + 28'(HALF)) >> FRAC_BITS);
        end else if (k == ST_TERM) begin
            s.term = 13'((28'(p.t1) * 28'(p.sq[2].root) + 28'(HALF)) >> FRAC_BITS);
        end else if (k == ST_QMUL) begin
            s.q_rem = 27'(27'(p.term) * 27'(p.sq[3].root));
            if (p.cb == '0) begin
                s.q_den = 15'd1;
            end else begin
                s.q_den = p.cb[15] ? 15'(-p.cb) : 15'(p.cb);
            end
        end else if (k == ST_QINIT) begin
            s.q_quo = '0;
            s.q_ovf = (43'(p.q_rem) >= (43'(p.q_den) << Q_STEPS));
        end else if (k >= ST_QDIV && k < ST_QDIV + Q_STEPS) begin
            sh = Q_STEPS - 1 - (k - ST_QDIV);
            ds = div_step(51'(p.q_rem), 36'(p.q_den), sh);
            s.q_rem = ds.rem[26:0];
            s.q_quo = {p.q_quo[14:0], ds.take};
        end else if (k == ST_RES) begin
            // A saturated quotient is large enough to pin the sum at either bound.
            sum = p.q_ovf ? 36'(16'hFFFF) : 36'(p.q_quo);
            if (p.cb[15]) begin
                sum = 36'(p.a_sel) - sum;
            end else begin
                sum = 36'(p.a_sel) + sum;
            end
            if (sum < 0) begin
                s.res = '0;
            end else if (sum > ONE) begin
                s.res = 15'(ONE);
            end else begin
                s.res = sum[14:0];
            end
        end
        return s;
    endfunction

    // The pipeline moves as one whenever its last stage is empty or being taken.
    // The first stage may also fill while the rest is stalled, provided it is empty.
    logic                pipe_adv;
    logic [N_STAGES-1:0] r_v;
    t_pl                 r_pl [N_STAGES];
    t_pl                 n_pl [N_STAGES];

    assign pipe_adv   = !r_v[N_STAGES-1] || i_out_ready;
    assign o_in_ready = pipe_adv || !r_v[0];

    always_comb begin
        n_pl[0]         = '{default: '0};
        n_pl[0].wi[0]   = i_in_dir_x;
        n_pl[0].wi[1]   = i_in_dir_y;
        n_pl[0].wi[2]   = i_in_dir_z;
        n_pl[0].wo[0]   = i_out_dir_x;
        n_pl[0].wo[1]   = i_out_dir_y;
        n_pl[0].wo[2]   = i_out_dir_z;
        n_pl[0].nv[0]   = i_normal_x;
        n_pl[0].nv[1]   = i_normal_y;
        n_pl[0].nv[2]   = i_normal_z;
        n_pl[0].use_sig = i_use_item_sigma;
        n_pl[0].sig     = i_item_sigma;
    end

    for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
        always_comb begin
            n_pl[g] = stage_fn(g, r_pl[g-1], r_oren_a, r_oren_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (o_in_ready) begin
                r_v[0] <= i_in_valid;
            end
            if (pipe_adv) begin
                r_v[N_STAGES-1:1] <= r_v[N_STAGES-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_pl[0] <= n_pl[0];
        end
        if (pipe_adv) begin
            for (int s = 1; s < N_STAGES; s++) begin
                r_pl[s] <= n_pl[s];
            end
        end
    end

    assign o_out_valid     = r_v[N_STAGES-1];
    assign o_diffuse_scale = r_pl[N_STAGES-1].res;

endmodule
